// File: src/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg: shared types for the dual stack machine core
// Transaction structs, opcodes, error codes and sequencer states.
// ----------------------------------------------------------------------------
package dsm_pkg;

  typedef struct packed {
    logic        operation;
    logic [15:0] load_address;
    logic [15:0] load_word;
    logic [7:0]  key_byte;
  } dsm_in_t;

  typedef struct packed {
    logic        char_valid;
    logic [7:0]  char_value;
    logic        char_dest;
    logic [15:0] pc_now;
    logic [15:0] top_value;
    logic        halted;
    logic [2:0]  error_code;
  } dsm_out_t;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_LIT = 6'd1, OP_DROP = 6'd2, OP_FRAME = 6'd3, OP_CALL = 6'd4,
    OP_EMIT = 6'd5, OP_HALT = 6'd6, OP_RET = 6'd7, OP_JMP = 6'd8, OP_DUP = 6'd9,
    OP_FETCH = 6'd10, OP_STORE = 6'd11, OP_KEY = 6'd12, OP_BZ = 6'd13,
    OP_OVER = 6'd14, OP_KILL = 6'd15, OP_LDL = 6'd16, OP_STL = 6'd17,
    OP_TOR = 6'd18, OP_FROMR = 6'd19, OP_ADD = 6'd20, OP_SUB = 6'd21,
    OP_MUL = 6'd22, OP_DIV = 6'd23, OP_MOD = 6'd24, OP_LAND = 6'd25,
    OP_LOR = 6'd26, OP_LNOT = 6'd27, OP_AND = 6'd28, OP_OR = 6'd29,
    OP_XOR = 6'd30, OP_EQ = 6'd31, OP_EMITO = 6'd32
  } opcode_t;

  localparam logic [15:0] OPCODE_COUNT = 16'd33;
  localparam logic [15:0] PC_LAST      = 16'hFFFF;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_DOVF = 3'd1, ERR_DUNF = 3'd2, ERR_RSTK = 3'd3,
    ERR_DIVZ = 3'd4, ERR_BADOP = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    RT_OUT, RT_MEMRD, RT_DIV, RT_RELOAD
  } route_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_OPC, S_EXEC, S_MEMRD, S_DIV, S_DIVWB,
    S_RELOAD, S_RLD2, S_OUT
  } state_t;

endpackage

// File: src/dual_stack_machine_core.sv
// ----------------------------------------------------------------------------
// dual_stack_machine_core: 16-bit dual stack processor
// Executes one instruction or writes one program word per transaction.
// ----------------------------------------------------------------------------
// Program load: written in IDLE, then OUT. Execute: FETCH, OPC, EXEC, OUT;
// fetch and frame reads add MEMRD, store ops RELOAD and RLD2, div/mod DIV
// (16-step shared divider) and DIVWB. Each instruction walks the program and
// stack memories in turn. Reset: synchronous; it then clears the program RAM,
// one word a cycle, with in_stall high. Stack contents are not cleared.
module dual_stack_machine_core
  import dsm_pkg::*;
#(
  parameter int DATA_DEPTH    = 128,
  parameter int RETURN_DEPTH  = 128,
  parameter int PROGRAM_WORDS = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dsm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dsm_out_t out_data
);

  localparam int DA = $clog2(DATA_DEPTH);
  localparam int DW = $clog2(DATA_DEPTH + 1);
  localparam int RA = $clog2(RETURN_DEPTH);
  localparam int RW = $clog2(RETURN_DEPTH + 1);
  localparam int PA = $clog2(PROGRAM_WORDS);

  logic [15:0] pmem [PROGRAM_WORDS];
  logic [15:0] dmem [DATA_DEPTH];
  logic [15:0] rmem [RETURN_DEPTH];

  state_t state_r, state_nxt;
  logic [15:0] ip_r, ip_nxt, fb_r, fb_nxt, tos_r, tos_nxt;
  logic [DW-1:0] dti_r, dti_nxt;
  logic [RW-1:0] rti_r, rti_nxt;
  logic halted_r, halted_nxt;
  err_t err_r, err_nxt;
  opcode_t opc_r, opc_nxt;
  logic bad_r, bad_nxt;
  logic cv_r, cv_nxt, cd_r, cd_nxt;
  logic [7:0] cval_r, cval_nxt;
  logic [7:0] key_r, key_nxt;
  logic [PA-1:0] clr_r, clr_nxt;
  logic [15:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  logic pm_we;
  logic [PA-1:0] pm_waddr;
  logic [15:0] pm_wdata, pm_raddr, pm_rdata_r, pm_rd;
  logic pm_inr_r;
  logic ds_we;
  logic [DA-1:0] ds_waddr, ds_raddr;
  logic [15:0] ds_wdata, ds_rdata_r;
  logic rs_we;
  logic [RA-1:0] rs_waddr;
  logic [15:0] rs_wdata, rs_rdata_r;

  logic in_acc;
  logic [DW-1:0] dti_m1, dti_m2;
  logic [RW-1:0] rti_m1;
  logic [15:0] nos, idx, ip_p1, ip_p2, key_sx, alu_r;
  logic [31:0] prod;
  logic [16:0] div_sh, div_diff;
  logic d_empty, d_full, d_lt2, r_empty, r_full, idx_ok, fb_ok;
  err_t ex_err;
  route_t ex_route;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign dti_m1   = dti_r - DW'(1);
  assign dti_m2   = dti_r - DW'(2);
  assign rti_m1   = rti_r - RW'(1);
  assign nos      = ds_rdata_r;
  assign idx      = fb_r - tos_r;
  assign ip_p1    = ip_r + 16'd1;
  assign ip_p2    = ip_r + 16'd2;
  assign key_sx   = {{8{key_r[7]}}, key_r};
  assign pm_rd    = pm_inr_r ? pm_rdata_r : 16'd0;
  assign prod     = nos * tos_r;
  assign div_sh   = {rem_r, quo_r[15]};
  assign div_diff = div_sh - {1'b0, tos_r};
  assign d_empty  = (dti_r == '0);
  assign d_full   = (dti_r == DW'(DATA_DEPTH));
  assign d_lt2    = (dti_r < DW'(2));
  assign r_empty  = (rti_r == '0);
  assign r_full   = (rti_r == RW'(RETURN_DEPTH));
  assign idx_ok   = ({1'b0, idx} < 17'(dti_r));
  assign fb_ok    = ({1'b0, fb_r} < 17'(dti_r));

  // memories
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    pm_rdata_r <= pmem[pm_raddr[PA-1:0]];
    pm_inr_r   <= ({1'b0, pm_raddr} < 17'(PROGRAM_WORDS));
    if (ds_we) dmem[ds_waddr] <= ds_wdata;
    ds_rdata_r <= dmem[ds_raddr];
    if (rs_we) rmem[rs_waddr] <= rs_wdata;
    rs_rdata_r <= rmem[rti_m1[RA-1:0]];
  end

  // combinational ALU for the binary ops
  always_comb begin
    case (opc_r)
      OP_ADD:  alu_r = nos + tos_r;
      OP_SUB:  alu_r = nos - tos_r;
      OP_MUL:  alu_r = prod[15:0];
      OP_LAND: alu_r = {15'd0, (nos != 16'd0) && (tos_r != 16'd0)};
      OP_LOR:  alu_r = {15'd0, (nos != 16'd0) || (tos_r != 16'd0)};
      OP_AND:  alu_r = nos & tos_r;
      OP_OR:   alu_r = nos | tos_r;
      OP_XOR:  alu_r = nos ^ tos_r;
      default: alu_r = {15'd0, nos == tos_r};
    endcase
  end

  // fault check and route
  always_comb begin
    ex_err   = ERR_NONE;
    ex_route = RT_OUT;
    if (bad_r) begin
      ex_err = ERR_BADOP;
    end else begin
      case (opc_r)
        OP_NOP, OP_HALT: ;
        OP_LIT, OP_FRAME, OP_KEY: if (d_full) ex_err = ERR_DOVF;
        OP_DROP, OP_EMIT, OP_EMITO, OP_JMP, OP_BZ, OP_LNOT:
          if (d_empty) ex_err = ERR_DUNF;
        OP_CALL, OP_TOR: begin
          if (d_empty) ex_err = ERR_DUNF;
          else if (r_full) ex_err = ERR_RSTK;
        end
        OP_RET: if (r_empty) ex_err = ERR_RSTK;
        OP_DUP: begin
          if (d_empty) ex_err = ERR_DUNF;
          else if (d_full) ex_err = ERR_DOVF;
        end
        OP_OVER: begin
          if (d_lt2) ex_err = ERR_DUNF;
          else if (d_full) ex_err = ERR_DOVF;
        end
        OP_FETCH: begin
          if (d_empty) ex_err = ERR_DUNF;
          else ex_route = RT_MEMRD;
        end
        OP_STORE: begin
          if (d_lt2) ex_err = ERR_DUNF;
          else ex_route = RT_RELOAD;
        end
        OP_KILL: begin
          if (!fb_ok) ex_err = ERR_DUNF;
          else ex_route = RT_MEMRD;
        end
        OP_LDL: begin
          if (d_empty || !idx_ok) ex_err = ERR_DUNF;
          else ex_route = RT_MEMRD;
        end
        OP_STL: begin
          if (d_lt2 || !idx_ok) ex_err = ERR_DUNF;
          else ex_route = RT_RELOAD;
        end
        OP_FROMR: begin
          if (d_full) ex_err = ERR_DOVF;
          else if (r_empty) ex_err = ERR_RSTK;
        end
        OP_DIV, OP_MOD: begin
          if (d_lt2) ex_err = ERR_DUNF;
          else if (tos_r == 16'd0) ex_err = ERR_DIVZ;
          else ex_route = RT_DIV;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_XOR, OP_EQ:
          if (d_lt2) ex_err = ERR_DUNF;
        default: ex_err = ERR_BADOP;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == PA'(PROGRAM_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.operation && !halted_r) state_nxt = S_FETCH;
          else state_nxt = S_OUT;
        end
      end
      S_FETCH: state_nxt = S_OPC;
      S_OPC:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (ex_err != ERR_NONE) state_nxt = S_OUT;
        else begin
          case (ex_route)
            RT_MEMRD:  state_nxt = S_MEMRD;
            RT_DIV:    state_nxt = S_DIV;
            RT_RELOAD: state_nxt = S_RELOAD;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_MEMRD:  state_nxt = S_OUT;
      S_DIV:    if (cnt_r == 4'd15) state_nxt = S_DIVWB;
      S_DIVWB:  state_nxt = S_OUT;
      S_RELOAD: state_nxt = S_RLD2;
      S_RLD2:   state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ip_nxt = ip_r; fb_nxt = fb_r; tos_nxt = tos_r; dti_nxt = dti_r; rti_nxt = rti_r;
    halted_nxt = halted_r; err_nxt = err_r; opc_nxt = opc_r; bad_nxt = bad_r;
    cv_nxt = cv_r; cd_nxt = cd_r; cval_nxt = cval_r; clr_nxt = clr_r; key_nxt = key_r;
    rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    pm_we = 1'b0; pm_waddr = clr_r; pm_wdata = 16'd0; pm_raddr = ip_r;
    ds_we = 1'b0; ds_waddr = dti_r[DA-1:0]; ds_wdata = tos_r; ds_raddr = dti_m2[DA-1:0];
    rs_we = 1'b0; rs_waddr = rti_r[RA-1:0]; rs_wdata = ip_p1;
    case (state_r)
      S_CLEAR: begin
        pm_we   = 1'b1;
        clr_nxt = clr_r + PA'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          cv_nxt = 1'b0; cd_nxt = 1'b0; cval_nxt = 8'd0;
          key_nxt = in_data.key_byte;
          if (!in_data.operation &&
              ({1'b0, in_data.load_address} < 17'(PROGRAM_WORDS))) begin
            pm_we    = 1'b1;
            pm_waddr = in_data.load_address[PA-1:0];
            pm_wdata = in_data.load_word;
          end
        end
      end
      S_OPC: begin
        pm_raddr = ip_p1;
        opc_nxt  = opcode_t'(pm_rd[5:0]);
        bad_nxt  = (pm_rd >= OPCODE_COUNT);
      end
      S_EXEC: begin
        pm_raddr = tos_r;
        if (ex_err != ERR_NONE) begin
          err_nxt = ex_err; halted_nxt = 1'b1;
        end else begin
          ip_nxt = ip_p1;
          case (opc_r)
            OP_LIT: begin
              ds_we = 1'b1; ds_wdata = pm_rd; tos_nxt = pm_rd;
              dti_nxt = dti_r + DW'(1); ip_nxt = ip_p2;
            end
            OP_DROP: begin dti_nxt = dti_m1; tos_nxt = nos; end
            OP_FRAME: begin
              ds_we = 1'b1; ds_wdata = fb_r; tos_nxt = fb_r;
              fb_nxt = 16'(dti_r); dti_nxt = dti_r + DW'(1);
            end
            OP_CALL: begin
              rs_we = 1'b1; rti_nxt = rti_r + RW'(1);
              ip_nxt = tos_r; dti_nxt = dti_m1; tos_nxt = nos;
            end
            OP_EMIT, OP_EMITO: begin
              cv_nxt = 1'b1; cval_nxt = tos_r[7:0]; cd_nxt = (opc_r == OP_EMITO);
              dti_nxt = dti_m1; tos_nxt = nos;
            end
            OP_HALT: begin ip_nxt = ip_r; halted_nxt = 1'b1; end
            OP_RET: begin ip_nxt = rs_rdata_r; rti_nxt = rti_m1; end
            OP_JMP: begin ip_nxt = tos_r; dti_nxt = dti_m1; tos_nxt = nos; end
            OP_DUP: begin ds_we = 1'b1; dti_nxt = dti_r + DW'(1); end
            OP_STORE: begin
              if ({1'b0, tos_r} < 17'(PROGRAM_WORDS)) begin
                pm_we = 1'b1; pm_waddr = tos_r[PA-1:0]; pm_wdata = nos;
              end
              dti_nxt = dti_m2;
            end
            OP_KEY: begin
              ds_we = 1'b1; ds_wdata = key_sx; tos_nxt = key_sx;
              dti_nxt = dti_r + DW'(1);
            end
            OP_BZ: begin
              ip_nxt = (tos_r == 16'd0) ? pm_rd : ip_p2;
              dti_nxt = dti_m1; tos_nxt = nos;
            end
            OP_OVER: begin
              ds_we = 1'b1; ds_wdata = nos; tos_nxt = nos; dti_nxt = dti_r + DW'(1);
            end
            OP_KILL: ds_raddr = fb_r[DA-1:0];
            OP_LDL:  ds_raddr = idx[DA-1:0];
            OP_STL: begin
              ds_we = 1'b1; ds_waddr = idx[DA-1:0]; ds_wdata = nos; dti_nxt = dti_m2;
            end
            OP_TOR: begin
              rs_we = 1'b1; rs_wdata = tos_r; rti_nxt = rti_r + RW'(1);
              dti_nxt = dti_m1; tos_nxt = nos;
            end
            OP_FROMR: begin
              ds_we = 1'b1; ds_wdata = rs_rdata_r; tos_nxt = rs_rdata_r;
              dti_nxt = dti_r + DW'(1); rti_nxt = rti_m1;
            end
            OP_LNOT: begin
              tos_nxt = {15'd0, tos_r == 16'd0};
              ds_we = 1'b1; ds_waddr = dti_m1[DA-1:0]; ds_wdata = tos_nxt;
            end
            OP_DIV, OP_MOD: begin
              ip_nxt = ip_r; rem_nxt = 16'd0; quo_nxt = nos; cnt_nxt = 4'd0;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_XOR, OP_EQ:
            begin
              ds_we = 1'b1; ds_waddr = dti_m2[DA-1:0]; ds_wdata = alu_r;
              tos_nxt = alu_r; dti_nxt = dti_m1;
            end
            default: ;
          endcase
        end
      end
      S_MEMRD: begin
        ds_we = 1'b1; ds_waddr = dti_m1[DA-1:0];
        case (opc_r)
          OP_FETCH: begin ds_wdata = pm_rd; tos_nxt = pm_rd; end
          OP_KILL:  begin ds_we = 1'b0; fb_nxt = ds_rdata_r; end
          default:  begin ds_wdata = ds_rdata_r; tos_nxt = ds_rdata_r; end
        endcase
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (!div_diff[16]) begin
          rem_nxt = div_diff[15:0]; quo_nxt = {quo_r[14:0], 1'b1};
        end else begin
          rem_nxt = div_sh[15:0]; quo_nxt = {quo_r[14:0], 1'b0};
        end
      end
      S_DIVWB: begin
        ds_we = 1'b1; ds_waddr = dti_m2[DA-1:0];
        ds_wdata = (opc_r == OP_MOD) ? rem_r : quo_r;
        tos_nxt = ds_wdata; dti_nxt = dti_m1; ip_nxt = ip_p1;
      end
      S_RELOAD: ds_raddr = dti_m1[DA-1:0];
      S_RLD2:   tos_nxt = ds_rdata_r;
      default: ;
    endcase
    if (ip_nxt == PC_LAST) halted_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; ip_r <= 16'd0; fb_r <= 16'd0; dti_r <= '0; rti_r <= '0;
      halted_r <= 1'b0; err_r <= ERR_NONE; clr_r <= '0;
      cv_r <= 1'b0; cd_r <= 1'b0; cval_r <= 8'd0;
    end else begin
      state_r <= state_nxt; ip_r <= ip_nxt; fb_r <= fb_nxt; dti_r <= dti_nxt;
      rti_r <= rti_nxt; halted_r <= halted_nxt; err_r <= err_nxt; clr_r <= clr_nxt;
      cv_r <= cv_nxt; cd_r <= cd_nxt; cval_r <= cval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt; opc_r <= opc_nxt; bad_r <= bad_nxt; key_r <= key_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
  end

  assign out_valid           = (state_r == S_OUT);
  assign out_data.char_valid = cv_r;
  assign out_data.char_value = cval_r;
  assign out_data.char_dest  = cd_r;
  assign out_data.pc_now     = ip_r;
  assign out_data.top_value  = d_empty ? 16'd0 : tos_r;
  assign out_data.halted     = halted_r;
  assign out_data.error_code = err_r;

  a_dti_range: assert property (@(posedge clk) disable iff (!rst_n)
    dti_r <= DW'(DATA_DEPTH)) else $error("data stack index out of range");
  a_rti_range: assert property (@(posedge clk) disable iff (!rst_n)
    rti_r <= RW'(RETURN_DEPTH)) else $error("return stack index out of range");
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |-> halted_r) else $error("error without halt");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (tos_r != 16'd0)) else $error("divide by zero in divider");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && state_r != S_CLEAR) |=> halted_r) else $error("halt cleared");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the dual stack machine core
// Builds random programs one instruction ahead of the program counter, writes
// each word and then executes it, and checks every result transaction against
// an in-bench model of the machine. The run ends with one halting event.
// ----------------------------------------------------------------------------
module tb_top
  import dsm_pkg::*;
();

  localparam int DDEPTH      = 128;
  localparam int RDEPTH      = 128;
  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 1000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  dsm_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dsm_out_t out_data;

  dual_stack_machine_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // machine model state
  logic [15:0] prog_mem [65536];
  logic [15:0] dstk [DDEPTH];
  logic [15:0] rstk [RDEPTH];
  int          dcnt;
  int          rcnt;
  logic [15:0] ip;
  logic [15:0] fbase;
  logic        hlt;
  logic [2:0]  err_latch;

  dsm_in_t  pending_q[$];
  dsm_out_t expected_q[$];
  int       item_cnt;
  int       mismatch_cnt;
  int       cycle_cnt;
  logic     in_fire;
  int       send_gap;
  int       stall_left;
  bit       calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [2:0] run_instr(input logic [7:0] key, output logic cv,
                                           output logic [7:0] cval, output logic cdest);
    logic [15:0] w, nxt, a, b, r, idx;
    cv    = 1'b0;
    cval  = 8'd0;
    cdest = 1'b0;
    w   = prog_mem[ip];
    nxt = ip + 16'd1;
    r   = '0;
    case (w)
      OP_NOP: ip = nxt;
      OP_LIT: begin
        if (dcnt >= DDEPTH) return ERR_DOVF;
        dstk[dcnt] = prog_mem[nxt]; dcnt++; ip = ip + 16'd2;
      end
      OP_DROP: begin
        if (dcnt < 1) return ERR_DUNF;
        dcnt--; ip = nxt;
      end
      OP_FRAME: begin
        if (dcnt >= DDEPTH) return ERR_DOVF;
        dstk[dcnt] = fbase; fbase = 16'(dcnt); dcnt++; ip = nxt;
      end
      OP_CALL: begin
        if (dcnt < 1) return ERR_DUNF;
        if (rcnt >= RDEPTH) return ERR_RSTK;
        rstk[rcnt] = nxt; rcnt++; dcnt--; ip = dstk[dcnt];
      end
      OP_EMIT, OP_EMITO: begin
        if (dcnt < 1) return ERR_DUNF;
        dcnt--; cv = 1'b1; cval = dstk[dcnt][7:0]; cdest = (w == OP_EMITO); ip = nxt;
      end
      OP_HALT: begin
        hlt = 1'b1;
        return ERR_NONE;
      end
      OP_RET: begin
        if (rcnt < 1) return ERR_RSTK;
        rcnt--; ip = rstk[rcnt];
      end
      OP_JMP: begin
        if (dcnt < 1) return ERR_DUNF;
        dcnt--; ip = dstk[dcnt];
      end
      OP_DUP: begin
        if (dcnt < 1) return ERR_DUNF;
        if (dcnt >= DDEPTH) return ERR_DOVF;
        dstk[dcnt] = dstk[dcnt-1]; dcnt++; ip = nxt;
      end
      OP_FETCH: begin
        if (dcnt < 1) return ERR_DUNF;
        dstk[dcnt-1] = prog_mem[dstk[dcnt-1]]; ip = nxt;
      end
      OP_STORE: begin
        if (dcnt < 2) return ERR_DUNF;
        prog_mem[dstk[dcnt-1]] = dstk[dcnt-2]; dcnt -= 2; ip = nxt;
      end
      OP_KEY: begin
        if (dcnt >= DDEPTH) return ERR_DOVF;
        dstk[dcnt] = {{8{key[7]}}, key}; dcnt++; ip = nxt;
      end
      OP_BZ: begin
        if (dcnt < 1) return ERR_DUNF;
        dcnt--;
        ip = (dstk[dcnt] == 16'd0) ? prog_mem[nxt] : ip + 16'd2;
      end
      OP_OVER: begin
        if (dcnt < 2) return ERR_DUNF;
        if (dcnt >= DDEPTH) return ERR_DOVF;
        dstk[dcnt] = dstk[dcnt-2]; dcnt++; ip = nxt;
      end
      OP_KILL: begin
        if (int'(fbase) >= dcnt) return ERR_DUNF;
        fbase = dstk[fbase]; ip = nxt;
      end
      OP_LDL: begin
        if (dcnt < 1) return ERR_DUNF;
        idx = fbase - dstk[dcnt-1];
        if (int'(idx) >= dcnt) return ERR_DUNF;
        dstk[dcnt-1] = dstk[idx]; ip = nxt;
      end
      OP_STL: begin
        if (dcnt < 2) return ERR_DUNF;
        idx = fbase - dstk[dcnt-1];
        if (int'(idx) >= dcnt) return ERR_DUNF;
        dstk[idx] = dstk[dcnt-2]; dcnt -= 2; ip = nxt;
      end
      OP_TOR: begin
        if (dcnt < 1) return ERR_DUNF;
        if (rcnt >= RDEPTH) return ERR_RSTK;
        dcnt--; rstk[rcnt] = dstk[dcnt]; rcnt++; ip = nxt;
      end
      OP_FROMR: begin
        if (dcnt >= DDEPTH) return ERR_DOVF;
        if (rcnt < 1) return ERR_RSTK;
        rcnt--; dstk[dcnt] = rstk[rcnt]; dcnt++; ip = nxt;
      end
      OP_LNOT: begin
        if (dcnt < 1) return ERR_DUNF;
        dstk[dcnt-1] = (dstk[dcnt-1] == 16'd0) ? 16'd1 : 16'd0; ip = nxt;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LAND, OP_LOR, OP_AND, OP_OR,
      OP_XOR, OP_EQ: begin
        if (dcnt < 2) return ERR_DUNF;
        a = dstk[dcnt-2];
        b = dstk[dcnt-1];
        case (w)
          OP_ADD:  r = a + b;
          OP_SUB:  r = a - b;
          OP_MUL:  r = a * b;
          OP_DIV: begin
            if (b == 16'd0) return ERR_DIVZ;
            r = a / b;
          end
          OP_MOD: begin
            if (b == 16'd0) return ERR_DIVZ;
            r = a % b;
          end
          OP_LAND: r = (a != 0 && b != 0) ? 16'd1 : 16'd0;
          OP_LOR:  r = (a != 0 || b != 0) ? 16'd1 : 16'd0;
          OP_AND:  r = a & b;
          OP_OR:   r = a | b;
          OP_XOR:  r = a ^ b;
          default: r = (a == b) ? 16'd1 : 16'd0;
        endcase
        dcnt--; dstk[dcnt-1] = r; ip = nxt;
      end
      default: return ERR_BADOP;
    endcase
    if (ip == PC_LAST) hlt = 1'b1;
    return ERR_NONE;
  endfunction

  function automatic dsm_out_t predict_result(input dsm_in_t t);
    dsm_out_t   res;
    logic [2:0] e;
    res = '0;
    if (!t.operation) begin
      prog_mem[t.load_address] = t.load_word;
    end else if (!hlt) begin
      e = run_instr(t.key_byte, res.char_valid, res.char_value, res.char_dest);
      if (e != ERR_NONE) begin
        err_latch = e; hlt = 1'b1;
        res.char_valid = 1'b0; res.char_value = '0; res.char_dest = 1'b0;
      end
    end
    res.pc_now     = ip;
    res.top_value  = (dcnt > 0) ? dstk[dcnt-1] : 16'd0;
    res.halted     = hlt;
    res.error_code = err_latch;
    return res;
  endfunction

  task automatic enqueue(input logic op, input logic [15:0] addr, input logic [15:0] word);
    dsm_in_t t;
    t.operation    = op;
    t.load_address = addr;
    t.load_word    = word;
    t.key_byte     = 8'($urandom);
    pending_q.push_back(t);
    expected_q.push_back(predict_result(t));
    item_cnt++;
  endtask

  // write the instruction (and its inline word) at the pc, then execute it
  task automatic run_op(input opcode_t op, input logic [15:0] extra);
    logic [15:0] pc;
    pc = ip;
    enqueue(1'b0, pc, 16'(op));
    if (op == OP_LIT || op == OP_BZ) enqueue(1'b0, pc + 16'd1, extra);
    enqueue(1'b1, 16'($urandom), 16'($urandom));
  endtask

  task automatic make_room(input int n);
    while (!hlt && dcnt > DDEPTH - n) run_op(OP_DROP, 16'd0);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit op_legal(input opcode_t op);
    logic [15:0] top;
    top = (dcnt > 0) ? dstk[dcnt-1] : 16'd0;
    case (op)
      OP_NOP:            return 1;
      OP_LIT, OP_FRAME, OP_KEY: return dcnt < DDEPTH;
      OP_DROP, OP_EMIT, OP_EMITO, OP_FETCH, OP_LNOT, OP_BZ: return dcnt >= 1;
      OP_CALL:           return dcnt >= 1 && dcnt < DDEPTH && rcnt < RDEPTH;
      OP_JMP:            return dcnt >= 1 && dcnt < DDEPTH;
      OP_RET:            return rcnt >= 1 && rstk[rcnt-1] != PC_LAST;
      OP_DUP:            return dcnt >= 1 && dcnt < DDEPTH;
      OP_OVER:           return dcnt >= 2 && dcnt < DDEPTH;
      OP_STORE:          return dcnt >= 2;
      OP_KILL:           return int'(fbase) < dcnt;
      OP_LDL, OP_STL:    return dcnt >= 1 && dcnt < DDEPTH;
      OP_TOR:            return dcnt >= 1 && rcnt < RDEPTH;
      OP_FROMR:          return dcnt < DDEPTH && rcnt >= 1;
      OP_DIV, OP_MOD:    return dcnt >= 2 && top != 16'd0;
      OP_HALT:           return 0;
      default:           return dcnt >= 2;
    endcase
  endfunction

  task automatic random_instr();
    opcode_t     op;
    logic [15:0] idx;
    if ($urandom_range(0, 99) < 12) enqueue(1'b0, 16'($urandom), rand_value());
    do op = opcode_t'($urandom_range(0, 32)); while (!op_legal(op));
    case (op)
      OP_JMP, OP_CALL: begin
        run_op(OP_LIT, 16'($urandom_range(0, 16'hFEFF)));
        run_op(op, 16'd0);
      end
      OP_LDL, OP_STL: begin
        idx = 16'($urandom_range(0, dcnt));
        run_op(OP_LIT, fbase - idx);
        run_op(op, 16'd0);
      end
      OP_LIT:  run_op(op, rand_value());
      OP_BZ:   run_op(op, 16'($urandom_range(0, 16'hFEFF)));
      default: run_op(op, 16'd0);
    endcase
  endtask

  task automatic final_event();
    case ($urandom_range(0, 6))
      0: run_op(OP_HALT, 16'd0);
      1: begin
        enqueue(1'b0, ip, 16'($urandom_range(33, 65535)));
        enqueue(1'b1, 16'd0, 16'd0);
      end
      2: begin
        make_room(1);
        run_op(OP_LIT, fbase - 16'd200);
        run_op(OP_LDL, 16'd0);
      end
      3: while (!hlt) run_op(OP_KEY, 16'd0);
      4: begin
        if (rcnt == 0) run_op(OP_RET, 16'd0);
        else begin
          make_room(1);
          while (!hlt) begin
            run_op(OP_KEY, 16'd0);
            run_op(OP_TOR, 16'd0);
          end
        end
      end
      5: begin
        make_room(2);
        run_op(OP_KEY, 16'd0);
        run_op(OP_LIT, 16'd0);
        run_op($urandom_range(0, 1) ? OP_DIV : OP_MOD, 16'd0);
      end
      default: begin
        make_room(1);
        run_op(OP_LIT, PC_LAST);
        run_op(OP_JMP, 16'd0);
      end
    endcase
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    foreach (prog_mem[i]) prog_mem[i] = '0;
    dcnt = 0; rcnt = 0; ip = '0; fbase = '0; hlt = 1'b0; err_latch = ERR_NONE;
    item_cnt = 0;
    // directed: word at the top address, literal extremes, a random key, not-of-zero,
    // both emit destinations, frame ops, wraparound arithmetic
    enqueue(1'b0, 16'hFFFF, 16'hFFFF);
    run_op(OP_LIT, 16'hFFFF);
    run_op(OP_FETCH, 16'd0);
    run_op(OP_LIT, 16'd0);
    run_op(OP_LNOT, 16'd0);
    run_op(OP_ADD, 16'd0);
    run_op(OP_EMIT, 16'd0);
    run_op(OP_KEY, 16'd0);
    run_op(OP_FRAME, 16'd0);
    run_op(OP_LIT, 16'd1);
    run_op(OP_LDL, 16'd0);
    run_op(OP_EMITO, 16'd0);
    while (item_cnt < ITEM_TARGET) random_instr();
    final_event();
    repeat (12) begin
      if ($urandom_range(0, 1)) enqueue(1'b1, 16'($urandom), 16'($urandom));
      else enqueue(1'b0, 16'($urandom), 16'($urandom));
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    in_fire   = 1'b0;
    send_gap  = 0;
    stall_left = 0;
    calm      = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    dsm_out_t exp_res;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction: %p", out_data);
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data.char_valid !== exp_res.char_valid
            || out_data.char_value !== exp_res.char_value
            || out_data.char_dest !== exp_res.char_dest
            || out_data.pc_now !== exp_res.pc_now
            || out_data.top_value !== exp_res.top_value
            || out_data.halted !== exp_res.halted
            || out_data.error_code !== exp_res.error_code) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %p got %p", exp_res, out_data);
        end
      end
    end
  end

endmodule

// File: filelist.f
src/dsm_pkg.sv
src/dual_stack_machine_core.sv
tb/tb_top.sv
